@@ design/efr_pkg.sv @@
package efr_pkg;

    localparam int HEADER_BYTES = 5;

    localparam logic [7:0] SIZE_MIN = 8'd2;
    localparam logic [7:0] SIZE_MAX = 8'd253;
    localparam logic [7:0] LEN_OFFSET = 8'd2;
    localparam logic [8:0] MOD_FLETCHER = 9'd255;

    localparam logic [7:0] EXPECTED_CODE_RESET = 8'd255;
    localparam logic [7:0] EXPECTED_OPCODE_RESET = 8'd128;
    localparam logic [7:0] MAX_RETRIES_RESET = 8'd10;

    localparam logic [1:0] REG_EXPECTED_CODE = 2'd0;
    localparam logic [1:0] REG_EXPECTED_OPCODE = 2'd1;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

    localparam logic [2:0] ST_MATCH = 3'd0;
    localparam logic [2:0] ST_CHECKSUM_BAD = 3'd1;
    localparam logic [2:0] ST_NOT_REQUESTED = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic       en;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [2:0] status;
        logic [7:0] event_code;
        logic [7:0] event_opcode;
        logic [7:0] msg_counter;
        logic [7:0] payload_size;
        logic       gave_up;
        logic       last;
    } result_t;

endpackage

@@ design/efr_parser.sv @@
module efr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        byte_value,
    input  logic              timed_out,
    input  efr_pkg::cfg_wr_t  cfg,
    output logic              has_result,
    output efr_pkg::result_t  result
);

    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_PAYLOAD = 1'b1;

    logic [7:0] expected_code_reg;
    logic [7:0] expected_opcode_reg;
    logic [7:0] max_retries_reg;

    logic       phase_reg, phase_next;
    logic [2:0] header_count_reg, header_count_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] opcode_reg, opcode_next;
    logic [7:0] counter_reg, counter_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] payload_pos_reg, payload_pos_next;
    logic [7:0] sum_low_reg, sum_low_next;
    logic [7:0] sum_high_reg, sum_high_next;
    logic [7:0] check_low_reg, check_low_next;
    logic [8:0] attempts_reg, attempts_next;

    logic [8:0] s1;
    logic [8:0] s2;
    logic [7:0] fl_low;
    logic [7:0] fl_high;
    logic [2:0] hc_inc;
    logic [8:0] pos_ext;
    logic [8:0] size_ext;
    logic [8:0] att_inc;
    logic [8:0] att_limit;
    logic       do_verdict;
    logic [2:0] verdict_status;
    logic       give;

    function automatic logic size_ok(input logic [7:0] s);
        size_ok = (s >= efr_pkg::SIZE_MIN) && (s <= efr_pkg::SIZE_MAX);
    endfunction

    // fletcher-16 running sums, mod 255
    always_comb
    begin
        s1 = {1'b0, sum_low_reg} + {1'b0, byte_value};
        if (s1 >= efr_pkg::MOD_FLETCHER)
        begin
            s1 = s1 - efr_pkg::MOD_FLETCHER;
        end
        s2 = {1'b0, sum_high_reg} + s1;
        if (s2 >= efr_pkg::MOD_FLETCHER)
        begin
            s2 = s2 - efr_pkg::MOD_FLETCHER;
        end
        fl_low = s1[7:0];
        fl_high = s2[7:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        header_count_next = header_count_reg;
        code_next = code_reg;
        opcode_next = opcode_reg;
        counter_next = counter_reg;
        size_next = size_reg;
        payload_pos_next = payload_pos_reg;
        sum_low_next = sum_low_reg;
        sum_high_next = sum_high_reg;
        check_low_next = check_low_reg;
        attempts_next = attempts_reg;
        has_result = 1'b0;
        result = '0;
        do_verdict = 1'b0;
        verdict_status = efr_pkg::ST_MATCH;
        give = 1'b0;
        hc_inc = header_count_reg + 3'd1;
        pos_ext = {1'b0, payload_pos_reg} + 9'd2;
        size_ext = {1'b0, size_reg};
        att_inc = attempts_reg + 9'd1;
        att_limit = {1'b0, max_retries_reg} + 9'd1;

        if (timed_out)
        begin
            do_verdict = 1'b1;
            verdict_status = efr_pkg::ST_TIMEOUT;
        end
        else if (phase_reg != PH_PAYLOAD)
        begin
            sum_low_next = fl_low;
            sum_high_next = fl_high;
            case (header_count_reg)
                3'd1: code_next = byte_value;
                3'd2: size_next = byte_value - efr_pkg::LEN_OFFSET;
                3'd3: opcode_next = byte_value;
                3'd4: counter_next = byte_value;
                default: ;
            endcase
            header_count_next = hc_inc;
            if ({29'd0, hc_inc} >= efr_pkg::HEADER_BYTES)
            begin
                if (!size_ok(size_next))
                begin
                    do_verdict = 1'b1;
                    verdict_status = efr_pkg::ST_BAD_LENGTH;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                    payload_pos_next = 8'd0;
                end
            end
        end
        else if (pos_ext < size_ext)
        begin
            has_result = 1'b1;
            result.kind = efr_pkg::KIND_DATA;
            result.data_byte = byte_value;
            result.byte_index = payload_pos_reg;
            result.status = efr_pkg::ST_MATCH;
            result.event_code = code_reg;
            result.event_opcode = opcode_reg;
            result.msg_counter = counter_reg;
            result.payload_size = size_ok(size_reg) ? size_reg : 8'd0;
            result.gave_up = 1'b0;
            result.last = 1'b0;
            sum_low_next = fl_low;
            sum_high_next = fl_high;
            payload_pos_next = payload_pos_reg + 8'd1;
        end
        else if (pos_ext == size_ext)
        begin
            check_low_next = byte_value;
            payload_pos_next = payload_pos_reg + 8'd1;
        end
        else
        begin
            do_verdict = 1'b1;
            if (check_low_reg != sum_low_reg || byte_value != sum_high_reg)
            begin
                verdict_status = efr_pkg::ST_CHECKSUM_BAD;
            end
            else if (code_reg != expected_code_reg || opcode_reg != expected_opcode_reg)
            begin
                verdict_status = efr_pkg::ST_NOT_REQUESTED;
            end
            else
            begin
                verdict_status = efr_pkg::ST_MATCH;
            end
        end

        if (do_verdict)
        begin
            if (verdict_status == efr_pkg::ST_MATCH)
            begin
                attempts_next = 9'd0;
            end
            else if (att_inc >= att_limit)
            begin
                give = 1'b1;
                attempts_next = 9'd0;
            end
            else
            begin
                attempts_next = att_inc;
            end
            has_result = 1'b1;
            result.kind = efr_pkg::KIND_VERDICT;
            result.data_byte = 8'd0;
            result.byte_index = 8'd0;
            result.status = verdict_status;
            result.event_code = code_next;
            result.event_opcode = opcode_next;
            result.msg_counter = counter_next;
            result.payload_size = size_ok(size_next) ? size_next : 8'd0;
            result.gave_up = give;
            result.last = 1'b1;
            // drop the frame and look for a new header
            phase_next = PH_HEADER;
            header_count_next = 3'd0;
            code_next = 8'd0;
            opcode_next = 8'd0;
            counter_next = 8'd0;
            size_next = 8'd0;
            payload_pos_next = 8'd0;
            sum_low_next = 8'd0;
            sum_high_next = 8'd0;
            check_low_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_code_reg <= efr_pkg::EXPECTED_CODE_RESET;
            expected_opcode_reg <= efr_pkg::EXPECTED_OPCODE_RESET;
            max_retries_reg <= efr_pkg::MAX_RETRIES_RESET;
        end
        else if (cfg.en)
        begin
            case (cfg.index)
                efr_pkg::REG_EXPECTED_CODE: expected_code_reg <= cfg.data;
                efr_pkg::REG_EXPECTED_OPCODE: expected_opcode_reg <= cfg.data;
                efr_pkg::REG_MAX_RETRIES: max_retries_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            header_count_reg <= 3'd0;
            code_reg <= 8'd0;
            opcode_reg <= 8'd0;
            counter_reg <= 8'd0;
            size_reg <= 8'd0;
            payload_pos_reg <= 8'd0;
            sum_low_reg <= 8'd0;
            sum_high_reg <= 8'd0;
            check_low_reg <= 8'd0;
            attempts_reg <= 9'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            header_count_reg <= header_count_next;
            code_reg <= code_next;
            opcode_reg <= opcode_next;
            counter_reg <= counter_next;
            size_reg <= size_next;
            payload_pos_reg <= payload_pos_next;
            sum_low_reg <= sum_low_next;
            sum_high_reg <= sum_high_next;
            check_low_reg <= check_low_next;
            attempts_reg <= attempts_next;
        end
    end

endmodule

@@ design/efr_out_buf.sv @@
module efr_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  efr_pkg::result_t  push_data,
    input  logic              out_stall,
    output logic              out_valid,
    output efr_pkg::result_t  out_data,
    output logic              full
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    efr_pkg::result_t main_data_reg;
    efr_pkg::result_t skid_data_reg;
    logic             pop;
    logic             load_main;
    logic             load_skid;
    logic             main_from_skid;

    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main = 1'b0;
        load_skid = 1'b0;
        main_from_skid = 1'b0;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                load_main = 1'b1;
                main_from_skid = 1'b1;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                load_main = 1'b1;
                main_valid_next = 1'b1;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            load_skid = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main)
        begin
            main_data_reg <= main_from_skid ? skid_data_reg : push_data;
        end
        if (load_skid)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data = main_data_reg;
    assign full = skid_valid_reg;

endmodule

@@ design/event_frame_receiver_fletcher_top.sv @@
// channel   handshake              request contents
// in        in_valid / in_stall    byte_value, timed_out
// out       out_valid / out_stall  kind, data_byte, byte_index, status, event_code,
//                                  event_opcode, msg_counter, payload_size, gave_up, last
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one input request per cycle while in_stall is low; a result is registered in
// the main register of the output buffer, or first in its skid register when
// the main register holds a stalled result; a two-entry output buffer keeps input
// flowing while one result waits; in_stall rises only when both entries are full
// reset clears the frame parser, the attempt count and the output buffer,
// and loads the register defaults; cfg_ready is always high
module event_frame_receiver_fletcher_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_value,
    input  logic       timed_out,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [2:0] status,
    output logic [7:0] event_code,
    output logic [7:0] event_opcode,
    output logic [7:0] msg_counter,
    output logic [7:0] payload_size,
    output logic       gave_up,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic             accept;
    logic             buf_full;
    logic             has_result;
    efr_pkg::result_t result;
    efr_pkg::result_t out_data;
    efr_pkg::cfg_wr_t cfg;

    assign cfg_ready = 1'b1;
    assign cfg.en = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data = cfg_data;

    assign in_stall = buf_full;
    assign accept = in_valid && !in_stall;

    efr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_value (byte_value),
        .timed_out  (timed_out),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    efr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && has_result),
        .push_data (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign kind = out_data.kind;
    assign data_byte = out_data.data_byte;
    assign byte_index = out_data.byte_index;
    assign status = out_data.status;
    assign event_code = out_data.event_code;
    assign event_opcode = out_data.event_opcode;
    assign msg_counter = out_data.msg_counter;
    assign payload_size = out_data.payload_size;
    assign gave_up = out_data.gave_up;
    assign last = out_data.last;

endmodule
